@@ hdl/adjacency_matrix_graph_store_top_assert.svh @@
// Assertion macros shared by the graph store modules.
// Each macro takes a label, the clock, the active-low reset, a condition,
// a consequence and a message.
`ifndef ADJACENCY_MATRIX_GRAPH_STORE_TOP_ASSERT_SVH
`define ADJACENCY_MATRIX_GRAPH_STORE_TOP_ASSERT_SVH

// The consequence holds in the same cycle as the condition.
`define AMGS_ASSERT_IMP(lbl, clk, rst_n, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error(msg);

// The consequence holds in the cycle after the condition.
`define AMGS_ASSERT_NXT(lbl, clk, rst_n, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/amgs_pkg.sv @@
package amgs_pkg;

	// Field widths of the command and result beats.
	localparam int OW = 3;
	localparam int VW = 4;
	localparam int CW = 16;
	localparam int SW = 2;
	localparam int NW = 5;

	// Operation codes.
	localparam logic [OW-1:0] OP_NEW      = 3'd0;
	localparam logic [OW-1:0] OP_WRITE    = 3'd1;
	localparam logic [OW-1:0] OP_READ     = 3'd2;
	localparam logic [OW-1:0] OP_LIST_OUT = 3'd3;
	localparam logic [OW-1:0] OP_LIST_IN  = 3'd4;

	// Result status codes.
	localparam logic [SW-1:0] ST_OK   = 2'd0;
	localparam logic [SW-1:0] ST_NONE = 2'd1;
	localparam logic [SW-1:0] ST_FULL = 2'd2;

	// Cost pattern that marks a missing edge.
	localparam logic [CW-1:0] NO_EDGE = 16'hFFFF;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic alloc;
		logic wr_edge;
		logic rd_result;
		logic scan_issue;
		logic scan_emit;
		logic none_result;
	} amgs_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic j_last;
		logic n_zero;
	} amgs_stat_t;

endpackage

@@ hdl/amgs_ctrl.sv @@
`include "adjacency_matrix_graph_store_top_assert.svh"

module amgs_ctrl import amgs_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [OW-1:0] op,
	input  amgs_stat_t    stat,
	output logic          busy,
	output amgs_cmd_t     cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_ALLOC,
		S_WRITE,
		S_RD_REQ,
		S_RD_RSP,
		S_COUNT,
		S_CTAIL,
		S_CHECK,
		S_EMIT,
		S_ETAIL
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   accept;

	assign accept = start && !busy_q;
	assign busy   = busy_q;

	// Commands follow directly from the current state and status; load marks an accepted start.
	assign cmd.load        = accept;
	assign cmd.alloc       = (state_q == S_ALLOC);
	assign cmd.wr_edge     = (state_q == S_WRITE);
	assign cmd.rd_result   = (state_q == S_RD_RSP);
	assign cmd.scan_issue  = (state_q == S_COUNT) || (state_q == S_EMIT);
	assign cmd.scan_emit   = (state_q == S_EMIT);
	assign cmd.none_result = (state_q == S_CHECK) && stat.n_zero;

	// Sequencer: single-beat operations, and the scan: a counting pass, then an emitting pass unless none is found.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (op) inside
							OP_NEW: begin
								state_q <= S_ALLOC;
								busy_q  <= 1'b1;
							end
							OP_WRITE: begin
								state_q <= S_WRITE;
								busy_q  <= 1'b1;
							end
							OP_READ: begin
								state_q <= S_RD_REQ;
								busy_q  <= 1'b1;
							end
							OP_LIST_OUT, OP_LIST_IN: begin
								state_q <= S_COUNT;
								busy_q  <= 1'b1;
							end
							default: begin
								state_q <= S_IDLE;
								busy_q  <= 1'b0;
							end
						endcase
					end
				end
				S_ALLOC, S_WRITE, S_RD_RSP, S_ETAIL: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
				S_RD_REQ: begin
					state_q <= S_RD_RSP;
				end
				S_COUNT: begin
					if (stat.j_last) begin
						state_q <= S_CTAIL;
					end
				end
				S_CTAIL: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (stat.n_zero) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (stat.j_last) begin
						state_q <= S_ETAIL;
					end
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	`AMGS_ASSERT_IMP(a_busy_state, clk, arst_n, 1'b1, busy_q == (state_q != S_IDLE), "busy disagrees with state")
	`AMGS_ASSERT_NXT(a_count_flow, clk, arst_n, (state_q == S_COUNT) && !stat.j_last, state_q == S_COUNT, "count pass ended early")

endmodule

@@ hdl/amgs_dp.sv @@
`include "adjacency_matrix_graph_store_top_assert.svh"

module amgs_dp import amgs_pkg::*; #(
	parameter int MAX_VERTICES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  amgs_cmd_t            cmd,
	input  logic [OW-1:0]        op,
	input  logic [VW-1:0]        vertex_a,
	input  logic [VW-1:0]        vertex_b,
	input  logic signed [CW-1:0] edge_cost,
	output amgs_stat_t           stat,
	output logic                 result_strobe,
	output logic [SW-1:0]        status,
	output logic [VW-1:0]        vertex_index,
	output logic signed [CW-1:0] cost_out,
	output logic [NW-1:0]        count,
	output logic                 last
);

	// Only indices below sixteen can be named, so the matrix side is capped there.
	localparam int N     = (MAX_VERTICES < 16) ? MAX_VERTICES : 16;
	localparam int IW    = $clog2(N);
	localparam int AW    = 2 * IW;
	localparam int DEPTH = 1 << AW;
	localparam int UW    = $clog2(MAX_VERTICES + 1);

	logic [VW-1:0]    a_q;
	logic [VW-1:0]    b_q;
	logic [CW-1:0]    cost_q;
	logic             a_ok_q;
	logic             ab_ok_q;
	logic             col_scan_q;

	logic [CW-1:0]    mem_q [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [CW-1:0]    rdata_q;
	logic             rvld_q;
	logic [AW-1:0]    addr;

	logic [IW-1:0]    j_q;
	logic [IW-1:0]    j_s1;
	logic             issue_s1;
	logic             emit_s1;
	logic             hit_s1;
	logic [NW-1:0]    n_q;
	logic [NW-1:0]    emit_cnt_q;

	logic [UW-1:0]    used_q;
	logic [UW-1:0]    used_nxt;
	logic             full;

	logic             strobe_q;
	logic [SW-1:0]    status_q;
	logic [VW-1:0]    index_q;
	logic [CW-1:0]    cost_o_q;
	logic [NW-1:0]    count_q;
	logic             last_q;

	// Latch the command beat and its range checks.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q        <= vertex_a;
			b_q        <= vertex_b;
			cost_q     <= edge_cost;
			a_ok_q     <= (int'(vertex_a) < N);
			ab_ok_q    <= (int'(vertex_a) < N) && (int'(vertex_b) < N);
			col_scan_q <= (op == OP_LIST_IN);
		end
	end

	// A scan walks a row or a column; single accesses use the pair of vertices.
	always_comb begin
		if (cmd.scan_issue) begin
			addr = col_scan_q ? {j_q, a_q[IW-1:0]} : {a_q[IW-1:0], j_q};
		end else begin
			addr = {a_q[IW-1:0], b_q[IW-1:0]};
		end
	end

	// Matrix store with a registered read port.
	always_ff @(posedge clk) begin
		if (cmd.wr_edge && ab_ok_q) begin
			mem_q[addr] <= cost_q;
		end
		rdata_q <= mem_q[addr];
	end

	// Per-entry written marks; an unwritten entry reads as no edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (cmd.wr_edge && ab_ok_q) begin
				vld_q[addr] <= 1'b1;
			end
			rvld_q <= vld_q[addr];
		end
	end

	// Scan index and the stage that meets the read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q      <= '0;
			issue_s1 <= 1'b0;
			emit_s1  <= 1'b0;
		end else begin
			j_q      <= cmd.scan_issue ? j_q + IW'(1) : '0;
			issue_s1 <= cmd.scan_issue;
			emit_s1  <= cmd.scan_emit;
		end
	end

	always_ff @(posedge clk) begin
		j_s1 <= j_q;
	end

	assign hit_s1 = issue_s1 && a_ok_q && rvld_q && (rdata_q != NO_EDGE);

	assign stat.j_last = (j_q == IW'(N - 1));
	assign stat.n_zero = (n_q == '0);

	assign used_nxt = used_q + UW'(1);
	assign full     = (used_q == UW'(MAX_VERTICES));

	// Result register, vertex allocation and the neighbour counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			n_q        <= '0;
			emit_cnt_q <= '0;
			strobe_q   <= 1'b0;
			status_q   <= ST_OK;
			index_q    <= '0;
			cost_o_q   <= NO_EDGE;
			count_q    <= '0;
			last_q     <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (cmd.load) begin
				n_q        <= '0;
				emit_cnt_q <= '0;
			end
			if (cmd.alloc) begin
				strobe_q <= 1'b1;
				cost_o_q <= NO_EDGE;
				last_q   <= 1'b1;
				if (full) begin
					status_q <= ST_FULL;
					index_q  <= '0;
					count_q  <= NW'(used_q);
				end else begin
					used_q   <= used_nxt;
					status_q <= ST_OK;
					index_q  <= VW'(used_q);
					count_q  <= NW'(used_nxt);
				end
			end
			if (cmd.wr_edge) begin
				strobe_q <= 1'b1;
				status_q <= ST_OK;
				index_q  <= '0;
				cost_o_q <= ab_ok_q ? cost_q : NO_EDGE;
				count_q  <= NW'(used_q);
				last_q   <= 1'b1;
			end
			if (cmd.rd_result) begin
				strobe_q <= 1'b1;
				status_q <= ST_OK;
				index_q  <= '0;
				cost_o_q <= (ab_ok_q && rvld_q) ? rdata_q : NO_EDGE;
				count_q  <= NW'(used_q);
				last_q   <= 1'b1;
			end
			if (cmd.none_result) begin
				strobe_q <= 1'b1;
				status_q <= ST_NONE;
				index_q  <= '0;
				cost_o_q <= NO_EDGE;
				count_q  <= '0;
				last_q   <= 1'b1;
			end
			if (hit_s1) begin
				if (emit_s1) begin
					strobe_q   <= 1'b1;
					status_q   <= ST_OK;
					index_q    <= VW'(j_s1);
					cost_o_q   <= rdata_q;
					count_q    <= n_q;
					last_q     <= (emit_cnt_q + NW'(1)) == n_q;
					emit_cnt_q <= emit_cnt_q + NW'(1);
				end else begin
					n_q <= n_q + NW'(1);
				end
			end
		end
	end

	assign result_strobe = strobe_q;
	assign status        = status_q;
	assign vertex_index  = index_q;
	assign cost_out      = $signed(cost_o_q);
	assign count         = count_q;
	assign last          = last_q;

	`AMGS_ASSERT_IMP(a_used_bound, clk, arst_n, 1'b1, used_q <= UW'(MAX_VERTICES), "vertex count beyond capacity")
	`AMGS_ASSERT_IMP(a_emit_bound, clk, arst_n, 1'b1, emit_cnt_q <= n_q, "more neighbours emitted than counted")
	`AMGS_ASSERT_IMP(a_none_shape, clk, arst_n, strobe_q && (status_q == ST_NONE), (count_q == '0) && last_q, "empty scan beat malformed")

endmodule

@@ hdl/adjacency_matrix_graph_store_top.sv @@
// Channel   Handshake                    Payload
// command   start in, busy out           op, vertex_a, vertex_b, edge_cost
// result    result_strobe out, one cycle status, vertex_index, cost_out, count, last
//
// A command beat is taken when start is high and busy is low.
// New vertex passes through S_ALLOC, write edge through S_WRITE, read edge through S_RD_REQ and S_RD_RSP.
// A neighbour list walks the N = min(MAX_VERTICES, 16) entries of a row or a column, one matrix
// read per cycle on the single memory port: a counting pass, then an emitting pass unless none is found.
// Reset clears the vertex count and the per-entry written marks at once; no clearing pass.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
module adjacency_matrix_graph_store_top import amgs_pkg::*; #(
	parameter int MAX_VERTICES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [OW-1:0]        op,
	input  logic [VW-1:0]        vertex_a,
	input  logic [VW-1:0]        vertex_b,
	input  logic signed [CW-1:0] edge_cost,
	output logic                 result_strobe,
	output logic [SW-1:0]        status,
	output logic [VW-1:0]        vertex_index,
	output logic signed [CW-1:0] cost_out,
	output logic [NW-1:0]        count,
	output logic                 last
);

	amgs_cmd_t  cmd;
	amgs_stat_t stat;

	// Sequencer.
	amgs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	// Matrix store, counters and result register.
	amgs_dp #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.op            (op),
		.vertex_a      (vertex_a),
		.vertex_b      (vertex_b),
		.edge_cost     (edge_cost),
		.stat          (stat),
		.result_strobe (result_strobe),
		.status        (status),
		.vertex_index  (vertex_index),
		.cost_out      (cost_out),
		.count         (count),
		.last          (last)
	);

endmodule
